>>> hw/rtl/pso_pkg.sv
// Package for the priority span overlay: sizes, payload structs, table entry
// layout, sequencer codes and the marker winner function.
// No dependencies; imported by pso_table and priority_span_overlay.
`default_nettype none

package pso_pkg;

    localparam int MAX_RUNS = 32;
    localparam int POS_BITS = 24;
    localparam int IDX_W    = $clog2(MAX_RUNS);
    localparam int CNT_W    = $clog2(MAX_RUNS + 1);
    localparam int UP_W     = POS_BITS + 1;

    localparam logic [1:0] KIND_OPEN = 2'd0;
    localparam logic [1:0] KIND_ADD  = 2'd1;
    localparam logic [1:0] KIND_EMIT = 2'd2;

    localparam logic [1:0] CFG_WINDOW_START = 2'd0;
    localparam logic [1:0] CFG_WINDOW_END   = 2'd1;
    localparam logic [1:0] CFG_OWNER_FIRST  = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [POS_BITS-1:0] marker_start;
        logic [POS_BITS-1:0] marker_end;
        logic signed [15:0]  marker_priority;
        logic [15:0]         marker_id;
        logic                owner_match;
    } in_t;

    typedef struct packed {
        logic [POS_BITS-1:0] run_length;
        logic                run_has_marker;
        logic [15:0]         run_marker_id;
        logic signed [15:0]  run_priority;
        logic                overflow;
        logic                last;
    } out_t;

    typedef struct packed {
        logic [POS_BITS-1:0] len;
        logic [15:0]         id;
        logic signed [15:0]  pri;
        logic                own;
        logic                has;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } tbl_req_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_CHK   = 7'b0000100,
        ST_SH_RD = 7'b0001000,
        ST_SH_WR = 7'b0010000,
        ST_SP_HI = 7'b0100000,
        ST_SP_LO = 7'b1000000
    } state_t;

    typedef enum logic [3:0] {
        PH_SPLIT_ST = 4'b0001,
        PH_SPLIT_EN = 4'b0010,
        PH_COMB     = 4'b0100,
        PH_EMIT     = 4'b1000
    } phase_t;

    // New marker takes the run: empty run, owner decides when enabled and
    // owners differ, else strictly higher priority.
    function automatic logic marker_wins(input entry_t old, input logic owner_first,
                                         input logic own, input logic signed [15:0] pri);
        logic take;
        take = (old.pri < pri);
        if (owner_first && (old.own != own))
            take = own;
        if (!old.has)
            take = 1'b1;
        return take;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pso_table.sv
// Run table storage: one write port and one registered read port.
// Depends on pso_pkg.
`default_nettype none

module pso_table (
    input  wire logic              clk,
    input  wire pso_pkg::tbl_req_t req,
    output pso_pkg::entry_t        rd_data
);
    import pso_pkg::*;

    entry_t mem [MAX_RUNS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/priority_span_overlay.sv
// Top level of the priority span overlay: handshakes, configuration
// registers and the sequencer that walks the run table.
// Depends on pso_pkg and pso_table.
`default_nettype none

// Open resets the table from the idle state; emit walks the runs, and
// the results stream through a one-entry output register that holds the walk
// while out_stall is high; add runs two split walks with shifting, then the
// combine walk. The single table read port shapes these walks: every entry
// visited takes a read state and a check state, every entry shifted a read
// state and a write state.
// One item at a time; in_stall is high while the sequencer is busy.
// Reset clears the run count, overflow flag, configuration registers and sequencer.
module priority_span_overlay (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pso_pkg::in_t                  in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pso_pkg::out_t                      out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [pso_pkg::POS_BITS-1:0]  cfg_data
);
    import pso_pkg::*;

    // Configuration registers
    logic [POS_BITS-1:0] win_start_reg;
    logic [POS_BITS-1:0] win_end_reg;
    logic                owner_first_reg;

    // Table bookkeeping
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                overflow_seen_reg, overflow_seen_next;

    // Sequencer
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;     // walk index
    logic [CNT_W-1:0]    k_reg, k_next;         // shift index
    logic [UP_W-1:0]     up_reg, up_next;       // start position of entry idx

    // Marker held for the add
    logic [POS_BITS-1:0] st_reg, st_next;
    logic [POS_BITS-1:0] en_reg, en_next;
    logic signed [15:0]  pri_reg, pri_next;
    logic [15:0]         id_reg, id_next;
    logic                own_reg, own_next;

    // Split point found by the walk
    logic [CNT_W-1:0]    hit_reg, hit_next;
    logic [UP_W-1:0]     hit_s_reg, hit_s_next;
    logic [UP_W-1:0]     hit_e_reg, hit_e_next;
    entry_t              hit_ent_reg, hit_ent_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    out_t                out_data_reg, out_data_next;

    tbl_req_t            req;
    entry_t              rd_ent;

    logic                in_xfer;
    logic [UP_W-1:0]     run_s;
    logic [UP_W-1:0]     run_e;
    logic [UP_W-1:0]     pos;
    logic [POS_BITS-1:0] clamp_st;
    logic [POS_BITS-1:0] clamp_en;
    entry_t              comb_ent;
    entry_t              new_ent;

    pso_table u_table (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_ent)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign run_s    = up_reg;
    assign run_e    = up_reg + {1'b0, rd_ent.len};
    assign pos      = (phase_reg == PH_SPLIT_EN) ? {1'b0, en_reg} : {1'b0, st_reg};
    assign clamp_st = (in_data.marker_start > win_start_reg) ? in_data.marker_start
                                                            : win_start_reg;
    assign clamp_en = (in_data.marker_end < win_end_reg) ? in_data.marker_end
                                                        : win_end_reg;

    always_comb
    begin
        comb_ent     = rd_ent;
        comb_ent.id  = id_reg;
        comb_ent.pri = pri_reg;
        comb_ent.own = own_reg;
        comb_ent.has = 1'b1;
    end

    // Configuration writes; index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg   <= '0;
            win_end_reg     <= '0;
            owner_first_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_START: win_start_reg   <= cfg_data;
                CFG_WINDOW_END:   win_end_reg     <= cfg_data;
                CFG_OWNER_FIRST:  owner_first_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        idx_next           = idx_reg;
        k_next             = k_reg;
        up_next            = up_reg;
        count_next         = count_reg;
        overflow_seen_next = overflow_seen_reg;
        st_next            = st_reg;
        en_next            = en_reg;
        pri_next           = pri_reg;
        id_next            = id_reg;
        own_next           = own_reg;
        hit_next           = hit_reg;
        hit_s_next         = hit_s_reg;
        hit_e_next         = hit_e_reg;
        hit_ent_next       = hit_ent_reg;
        out_data_next      = out_data_reg;
        out_valid_next     = out_valid_reg && out_stall;
        req                = '0;
        new_ent            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_data.kind)
                        KIND_OPEN:
                        begin
                            overflow_seen_next = 1'b0;
                            count_next         = '0;
                            if (win_end_reg > win_start_reg)
                            begin
                                new_ent.len = win_end_reg - win_start_reg;
                                req.wr_en   = 1'b1;
                                req.wr_addr = '0;
                                req.wr_data = new_ent;
                                count_next  = CNT_W'(1);
                            end
                        end
                        KIND_ADD:
                        begin
                            st_next  = clamp_st;
                            en_next  = clamp_en;
                            pri_next = in_data.marker_priority;
                            id_next  = in_data.marker_id;
                            own_next = in_data.owner_match;
                            if (clamp_st <= clamp_en)
                            begin
                                phase_next = PH_SPLIT_ST;
                                idx_next   = '0;
                                up_next    = {1'b0, win_start_reg};
                                state_next = ST_RD;
                            end
                        end
                        KIND_EMIT:
                        begin
                            phase_next = PH_EMIT;
                            idx_next   = '0;
                            state_next = ST_RD;
                        end
                        default: ;
                    endcase
                end
            end

            ST_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = idx_reg[IDX_W-1:0];
                    state_next  = ST_CHK;
                end
                else
                begin
                    // Walk finished: advance to the next phase
                    idx_next = '0;
                    up_next  = {1'b0, win_start_reg};
                    case (phase_reg)
                        PH_SPLIT_ST: phase_next = PH_SPLIT_EN;
                        PH_SPLIT_EN: phase_next = PH_COMB;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end

            ST_CHK:
            begin
                case (phase_reg)
                    PH_SPLIT_ST, PH_SPLIT_EN:
                    begin
                        if ((pos > run_s) && (pos < run_e))
                        begin
                            hit_next     = idx_reg;
                            hit_s_next   = run_s;
                            hit_e_next   = run_e;
                            hit_ent_next = rd_ent;
                            if (count_reg >= CNT_W'(MAX_RUNS))
                            begin
                                // Drop the split and move on
                                overflow_seen_next = 1'b1;
                                idx_next           = count_reg;
                                state_next         = ST_RD;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                state_next = (count_reg > idx_reg + CNT_W'(1)) ? ST_SH_RD
                                                                               : ST_SP_HI;
                            end
                        end
                        else
                        begin
                            up_next    = run_e;
                            idx_next   = idx_reg + CNT_W'(1);
                            state_next = ST_RD;
                        end
                    end
                    PH_COMB:
                    begin
                        if (({1'b0, st_reg} <= run_s) && (run_e <= {1'b0, en_reg})
                            && marker_wins(rd_ent, owner_first_reg, own_reg, pri_reg))
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_addr = idx_reg[IDX_W-1:0];
                            req.wr_data = comb_ent;
                        end
                        up_next    = run_e;
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_RD;
                    end
                    default:
                    begin
                        // Emit: hold until the output register frees up
                        if (!out_valid_reg || !out_stall)
                        begin
                            out_valid_next               = 1'b1;
                            out_data_next.run_length     = rd_ent.len;
                            out_data_next.run_has_marker = rd_ent.has;
                            out_data_next.run_marker_id  = rd_ent.has ? rd_ent.id : 16'd0;
                            out_data_next.run_priority   = rd_ent.has ? rd_ent.pri : 16'sd0;
                            out_data_next.overflow       = overflow_seen_reg;
                            out_data_next.last = (idx_reg == count_reg - CNT_W'(1));
                            idx_next   = idx_reg + CNT_W'(1);
                            state_next = ST_RD;
                        end
                    end
                endcase
            end

            ST_SH_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = IDX_W'(k_reg - CNT_W'(1));
                state_next  = ST_SH_WR;
            end

            ST_SH_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = k_reg[IDX_W-1:0];
                req.wr_data = rd_ent;
                k_next      = k_reg - CNT_W'(1);
                state_next  = (k_reg - CNT_W'(1) > hit_reg + CNT_W'(1)) ? ST_SH_RD
                                                                        : ST_SP_HI;
            end

            ST_SP_HI:
            begin
                new_ent     = hit_ent_reg;
                new_ent.len = POS_BITS'(hit_e_reg - pos);
                req.wr_en   = 1'b1;
                req.wr_addr = IDX_W'(hit_reg + CNT_W'(1));
                req.wr_data = new_ent;
                state_next  = ST_SP_LO;
            end

            ST_SP_LO:
            begin
                new_ent     = hit_ent_reg;
                new_ent.len = POS_BITS'(pos - hit_s_reg);
                req.wr_en   = 1'b1;
                req.wr_addr = hit_reg[IDX_W-1:0];
                req.wr_data = new_ent;
                count_next  = count_reg + CNT_W'(1);
                // Split done: end this walk
                idx_next    = count_reg + CNT_W'(1);
                state_next  = ST_RD;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            phase_reg         <= PH_SPLIT_ST;
            count_reg         <= '0;
            overflow_seen_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            idx_reg           <= '0;
            k_reg             <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            count_reg         <= count_next;
            overflow_seen_reg <= overflow_seen_next;
            out_valid_reg     <= out_valid_next;
            idx_reg           <= idx_next;
            k_reg             <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_reg       <= up_next;
        st_reg       <= st_next;
        en_reg       <= en_next;
        pri_reg      <= pri_next;
        id_reg       <= id_next;
        own_reg      <= own_next;
        hit_reg      <= hit_next;
        hit_s_reg    <= hit_s_next;
        hit_e_reg    <= hit_e_next;
        hit_ent_reg  <= hit_ent_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RUNS))
        else $error("run count beyond table size");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(phase_reg == PH_EMIT))
        else $error("result produced outside an emit");

    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_data.kind == KIND_OPEN) |=> (count_reg <= CNT_W'(1)))
        else $error("open left more than one run");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(overflow_seen_reg) |-> $past(count_reg) == CNT_W'(MAX_RUNS))
        else $error("overflow flagged with table space left");
`endif

endmodule

`default_nettype wire

>>> tb/priority_span_overlay_test.sv
// Testbench for priority_span_overlay: directed and random open/add/emit
// transfers checked against an in-bench run table predictor.
// Depends on pso_pkg and the priority_span_overlay RTL.
`default_nettype none

module priority_span_overlay_test;
    import pso_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = CFG_WINDOW_START;
    logic [23:0] cfg_data = '0;

    priority_span_overlay dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Predictor state: window registers and the run table.
    logic [23:0] win_lo, win_hi;
    logic        own_first;
    logic [23:0] tbl_len [MAX_RUNS];
    logic [15:0] tbl_id  [MAX_RUNS];
    logic signed [15:0] tbl_pri [MAX_RUNS];
    logic        tbl_has [MAX_RUNS];
    logic        tbl_own [MAX_RUNS];
    int          run_total;
    logic        ovf_sticky;

    out_t expected_runs[$];
    int   mismatches = 0;
    logic stall_enable = 1'b1;

    // Split the run that strictly contains pos; skip and flag when full.
    function automatic void split_run(logic [24:0] pos);
        logic [24:0] lo, hi;
        lo = {1'b0, win_lo};
        for (int i = 0; i < run_total; i++) begin
            hi = lo + tbl_len[i];
            if (pos > lo && pos < hi) begin
                if (run_total >= MAX_RUNS) begin
                    ovf_sticky = 1'b1;
                    return;
                end
                for (int k = run_total; k > i + 1; k--) begin
                    tbl_len[k] = tbl_len[k-1];
                    tbl_id[k]  = tbl_id[k-1];
                    tbl_pri[k] = tbl_pri[k-1];
                    tbl_has[k] = tbl_has[k-1];
                    tbl_own[k] = tbl_own[k-1];
                end
                tbl_len[i+1] = 24'(hi - pos);
                tbl_id[i+1]  = tbl_id[i];
                tbl_pri[i+1] = tbl_pri[i];
                tbl_has[i+1] = tbl_has[i];
                tbl_own[i+1] = tbl_own[i];
                tbl_len[i]   = 24'(pos - lo);
                run_total++;
                return;
            end
            lo = hi;
        end
    endfunction

    // Advance the table by one item and queue any runs it emits.
    function automatic void predict_runs(in_t it);
        logic [24:0] st, en, lo;
        logic take;
        out_t r;
        case (it.kind)
            KIND_OPEN: begin
                ovf_sticky = 1'b0;
                run_total = 0;
                if (win_hi > win_lo) begin
                    tbl_len[0] = win_hi - win_lo;
                    tbl_id[0] = '0; tbl_pri[0] = '0;
                    tbl_has[0] = 1'b0; tbl_own[0] = 1'b0;
                    run_total = 1;
                end
            end
            KIND_ADD: begin
                st = (it.marker_start > win_lo) ? it.marker_start : win_lo;
                en = (it.marker_end < win_hi) ? it.marker_end : win_hi;
                if (st <= en) begin
                    split_run(st);
                    split_run(en);
                    lo = {1'b0, win_lo};
                    for (int i = 0; i < run_total; i++) begin
                        if (st <= lo && lo + tbl_len[i] <= en) begin
                            take = tbl_pri[i] < it.marker_priority;
                            if (own_first && tbl_own[i] != it.owner_match)
                                take = it.owner_match;
                            if (!tbl_has[i]) take = 1'b1;
                            if (take) begin
                                tbl_id[i] = it.marker_id;
                                tbl_pri[i] = it.marker_priority;
                                tbl_has[i] = 1'b1;
                                tbl_own[i] = it.owner_match;
                            end
                        end
                        lo = lo + tbl_len[i];
                    end
                end
            end
            KIND_EMIT: begin
                for (int i = 0; i < run_total; i++) begin
                    r.run_length     = tbl_len[i];
                    r.run_has_marker = tbl_has[i];
                    r.run_marker_id  = tbl_has[i] ? tbl_id[i] : 16'd0;
                    r.run_priority   = tbl_has[i] ? tbl_pri[i] : 16'sd0;
                    r.overflow       = ovf_sticky;
                    r.last           = (i == run_total - 1);
                    expected_runs    = {expected_runs, r};
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Check each run transfer against the oldest expectation.
    always @(posedge clk) begin
        out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected run transfer %p", out_data);
            end else begin
                want = expected_runs.pop_front();
                if (out_data.run_length !== want.run_length
                    || out_data.run_has_marker !== want.run_has_marker
                    || out_data.run_marker_id !== want.run_marker_id
                    || out_data.run_priority !== want.run_priority
                    || out_data.overflow !== want.overflow
                    || out_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("run mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
    end

    // Drive the receiver stall at random on the falling edge.
    always @(negedge clk) begin
        int hold;
        if (!stall_enable) out_stall <= 1'b0;
        else if (hold > 0) begin
            hold--;
            out_stall <= 1'b1;
        end else begin
            hold = gap_len();
            out_stall <= (hold > 0);
        end
    end

    // Send one item and predict it at acceptance. Valid stays high after the
    // transfer so a following item can go back to back; a gap drops it first.
    task automatic send_item(in_t it, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        predict_runs(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_runs.size() != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // Write one register while the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        in_valid <= 1'b0;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_WINDOW_START: win_lo = val;
            CFG_WINDOW_END:   win_hi = val;
            default:          own_first = val[0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic in_t make_item(logic [1:0] k, logic [23:0] s, logic [23:0] e,
                                      logic [15:0] p, logic [15:0] id, logic o);
        in_t it;
        it.kind = k; it.marker_start = s; it.marker_end = e;
        it.marker_priority = p; it.marker_id = id; it.owner_match = o;
        return it;
    endfunction

    function automatic in_t rand_marker(logic [23:0] lo, logic [23:0] hi);
        logic [23:0] a, b;
        a = 24'($urandom_range(lo, hi));
        b = 24'($urandom_range(lo, hi));
        if ($urandom_range(0, 5) == 0) begin
            a = 24'($urandom); b = 24'($urandom);
        end else if (a > b && $urandom_range(0, 3) != 0) begin
            logic [23:0] t;
            t = a; a = b; b = t;
        end
        return make_item(KIND_ADD, a, b, 16'($urandom), 16'($urandom),
                         1'($urandom_range(0, 1)));
    endfunction

    // Extremes: full window, ties, owner precedence, empty span, stray kind.
    task automatic test_directed();
        write_reg(CFG_WINDOW_START, 24'd0);
        write_reg(CFG_WINDOW_END, 24'hFFFFFF);
        write_reg(CFG_OWNER_FIRST, 24'd0);
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_ADD, 24'd0, 24'hFFFFFF, 16'h7FFF, 16'hFFFF, 1));
        send_item(make_item(KIND_ADD, 24'd100, 24'd200, 16'h7FFF, 16'h1234, 0));
        send_item(make_item(KIND_ADD, 24'd50, 24'd150, 16'h8000, 16'h0001, 0));
        send_item(make_item(KIND_ADD, 24'd300, 24'd300, 16'h0005, 16'h0002, 1));
        send_item(make_item(KIND_ADD, 24'hFFFFFE, 24'hFFFFFF, 16'h8000, 16'h0, 0));
        send_item(make_item(2'd3, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        wait_drained();
        write_reg(CFG_WINDOW_START, 24'd1000);
        write_reg(CFG_WINDOW_END, 24'd2000);
        write_reg(CFG_OWNER_FIRST, 24'd1);
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_ADD, 24'd0, 24'd500, 16'd9, 16'd7, 1));
        send_item(make_item(KIND_ADD, 24'd1200, 24'd1500, 16'd10, 16'd3, 0));
        send_item(make_item(KIND_ADD, 24'd1300, 24'd1400, 16'sd1, 16'd4, 1));
        send_item(make_item(KIND_ADD, 24'd1300, 24'd1400, 16'sd100, 16'd5, 0));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        wait_drained();
        // Move the window without reopening: the table is walked live.
        write_reg(CFG_WINDOW_START, 24'd1100);
        send_item(make_item(KIND_ADD, 24'd1100, 24'd1600, 16'd50, 16'd8, 1));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        wait_drained();
        // Empty and inverted windows give no runs.
        write_reg(CFG_WINDOW_END, 24'd1100);
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        wait_drained();
        write_reg(CFG_WINDOW_END, 24'd5);
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_ADD, 24'd0, 24'd10, 16'd1, 16'd1, 0));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    // Fill the table past its size so splits drop and the flag sticks.
    task automatic test_overflow();
        write_reg(CFG_WINDOW_START, 24'd0);
        write_reg(CFG_WINDOW_END, 24'd200);
        write_reg(CFG_OWNER_FIRST, 24'd0);
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
        for (int i = 1; i < 45; i++)
            send_item(make_item(KIND_ADD, 24'(i * 4), 24'(i * 4 + 1), 16'(i), 16'(i), 0));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
        wait_drained();
    endtask

    // Random sessions: open, a handful of adds, emit, with some noise.
    task automatic test_random();
        logic [23:0] lo, hi;
        int sent, n;
        sent = 0;
        while (sent < 330) begin
            case ($urandom_range(0, 3))
                0: begin
                    lo = 24'($urandom);
                    hi = 24'(lo + $urandom_range(0, 60));
                end
                1: begin lo = 24'hFFFF00; hi = 24'hFFFFFF; end
                default: begin
                    lo = 24'($urandom_range(0, 1000));
                    hi = 24'(lo + $urandom_range(1, 400));
                end
            endcase
            if (hi < lo) hi = 24'hFFFFFF;
            write_reg(CFG_WINDOW_START, lo);
            write_reg(CFG_WINDOW_END, hi);
            write_reg(CFG_OWNER_FIRST, 24'($urandom_range(0, 1)));
            send_item(make_item(KIND_OPEN, 0, 0, 0, 0, 0));
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_item(2'($urandom_range(0, 3)), 24'($urandom),
                                        24'($urandom), 16'($urandom), 16'($urandom),
                                        1'($urandom_range(0, 1))));
                else
                    send_item(rand_marker(lo, hi), $urandom_range(0, 4) == 0);
                if ($urandom_range(0, 6) == 0) begin
                    send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
                    sent++;
                end
            end
            send_item(make_item(KIND_EMIT, 0, 0, 0, 0, 0));
            sent += n + 2;
            // Sometimes flip the receiver stall for the next session.
            if ($urandom_range(0, 3) == 0) stall_enable = ~stall_enable;
            wait_drained();
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        win_lo = '0; win_hi = '0; own_first = 1'b0;
        run_total = 0; ovf_sticky = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_overflow();
        test_random();
        wait_drained();
        if (mismatches == 0 && expected_runs.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
